### rtl/emb_pkg.sv
// Shared types and constants for the embedding lookup and gradient engine.
package emb_pkg;

	typedef enum logic [1:0] {
		REQ_WRITE   = 2'd0,
		REQ_FORWARD = 2'd1,
		REQ_GRAD    = 2'd2,
		REQ_NONE    = 2'd3
	} req_t;

	typedef enum logic [2:0] {
		KIND_ACK     = 3'd0,
		KIND_EMBED   = 3'd1,
		KIND_GRAD    = 3'd2,
		KIND_RANGE   = 3'd3,
		KIND_NOCACHE = 3'd4
	} kind_t;

	localparam int POS_W    = 8;
	localparam int COUNT_W  = 9;
	localparam int VLEN_W   = 7;
	localparam int ROWS_W   = 11;
	localparam int ELEM_W   = 6;
	localparam int WORD_W   = 16;
	localparam int GRAD_W   = 24;
	localparam int EPOCH_W  = 8;
	localparam int DIV_STEPS = 8;

	localparam logic signed [GRAD_W-1:0] GRAD_MAX = 24'sh7FFFFF;
	localparam logic signed [GRAD_W-1:0] GRAD_MIN = 24'sh800000;

endpackage

### rtl/emb_remu.sv
// Iterative restoring remainder unit: position modulo cached count, one bit per cycle.
module emb_remu
	import emb_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic [POS_W-1:0]   dividend,
	input  logic [COUNT_W-1:0] divisor,
	output logic               done,
	output logic [POS_W-1:0]   rem
);

	logic [POS_W-1:0]   num_q;
	logic [COUNT_W-1:0] den_q;
	logic [COUNT_W-1:0] r_q;
	logic [2:0]         cnt_q;
	logic               busy_q;
	logic               done_q;
	logic [COUNT_W-1:0] trial;

	// The partial remainder stays below the divisor, so its low bits hold it.
	assign trial = {r_q[COUNT_W-2:0], num_q[POS_W-1]};
	assign done  = done_q;
	assign rem   = r_q[POS_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
			r_q    <= '0;
			num_q  <= '0;
			den_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
				r_q    <= '0;
				num_q  <= dividend;
				den_q  <= divisor;
			end else if (busy_q) begin
				num_q <= {num_q[POS_W-2:0], 1'b0};
				if (trial >= den_q) begin
					r_q <= trial - den_q;
				end else begin
					r_q <= trial;
				end
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'(DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	a_div_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> divisor != '0) else $error("remainder started with zero divisor");
	a_rem_below: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> {1'b0, rem} < den_q) else $error("remainder not below divisor");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy_q) else $error("remainder done while still iterating");

endmodule

### rtl/embedding_lookup_and_gradient.sv
// Top level of the embedding table engine: sequencer, weight, gradient and token cache memories.
//
//   Channel   Handshake                 Payload
//   input     start, busy               req_type, token, position, element_index, value, first
//   result    result_strobe             kind, embed_value, grad_sum, out_element, last
//   config    cfg_we                    cfg_index, cfg_data
//
// A weight write or rejected token gives one registered result; an unused request gives none.
// A forward token is accepted, then ST_FWD reads one table word per cycle, vl words in all.
// A gradient element passes accept, check, a wait on the 8-step remainder unit,
// then token cache, gradient read and update; an empty cache or an element past the
// vector ends at the check.
// After reset, and when the pass counter wraps on a backward pass start, the gradient
// table is swept, one word a cycle over all MAX_ROWS * MAX_VECTOR words, with busy high.
// Results come on result_strobe, none for an unused request; the receiver cannot stall.
module embedding_lookup_and_gradient
	import emb_pkg::*;
#(
	parameter int MAX_ROWS      = 1024,
	parameter int MAX_VECTOR    = 64,
	parameter int MAX_POSITIONS = 256
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     start,
	output logic                     busy,
	input  logic [1:0]               req_type,
	input  logic signed [WORD_W-1:0] token,
	input  logic [POS_W-1:0]         position,
	input  logic [ELEM_W-1:0]        element_index,
	input  logic signed [WORD_W-1:0] value,
	input  logic                     first,
	output logic                     result_strobe,
	output logic [2:0]               kind,
	output logic signed [WORD_W-1:0] embed_value,
	output logic signed [GRAD_W-1:0] grad_sum,
	output logic [ELEM_W-1:0]        out_element,
	output logic                     last,
	input  logic                     cfg_we,
	input  logic                     cfg_index,
	input  logic [ROWS_W-1:0]        cfg_data
);

	localparam int WORDS  = MAX_ROWS * MAX_VECTOR;
	localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
	localparam int RW     = $clog2(MAX_ROWS);
	localparam int CDEPTH = (MAX_POSITIONS < 256) ? MAX_POSITIONS : 256;
	localparam int CW     = (CDEPTH > 1) ? $clog2(CDEPTH) : 1;

	typedef enum logic [3:0] {
		ST_IDLE, ST_SWEEP, ST_FWD, ST_GCHK, ST_GDIV, ST_GROW, ST_GADR, ST_GSUM
	} state_t;

	state_t state_q;

	logic [ROWS_W-1:0]  rows_cfg_q;
	logic [VLEN_W-1:0]  vlen_cfg_q;
	logic [COUNT_W-1:0] count_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [AW-1:0]      sweep_q;
	logic               sweep_grad_q;
	logic [AW-1:0]      base_q;
	logic [AW-1:0]      gaddr_q;
	logic [VLEN_W-1:0]  d_q;
	logic [POS_W-1:0]   pos_q;
	logic [ELEM_W-1:0]  elem_q;
	logic signed [WORD_W-1:0] val_q;

	logic               strobe_q;
	kind_t              kind_q;
	logic [WORD_W-1:0]  oembed_q;
	logic [GRAD_W-1:0]  ograd_q;
	logic [ELEM_W-1:0]  oelem_q;
	logic               olast_q;
	logic               from_mem_q;

	logic [WORD_W-1:0]           wmem [WORDS];
	logic [EPOCH_W+GRAD_W-1:0]   gmem [WORDS];
	logic [RW-1:0]               cmem [CDEPTH];
	logic [WORD_W-1:0]           wrd_q;
	logic [EPOCH_W+GRAD_W-1:0]   grd_q;
	logic [RW-1:0]               crd_q;

	logic [16:0]        rows_eff;
	logic [VLEN_W-1:0]  vl;
	logic               accept;
	logic               tok_good;
	logic               wr_good;
	logic               pos_cached;
	logic [COUNT_W-1:0] pos_next;
	logic [COUNT_W-1:0] count_base;
	logic [AW-1:0]      wr_addr;
	logic [AW-1:0]      tok_base;
	logic [AW-1:0]      fwd_addr;
	logic               div_start;
	logic               div_done;
	logic [POS_W-1:0]   div_rem;
	logic signed [GRAD_W:0] sum_wide;
	logic signed [GRAD_W-1:0] sum_sat;
	logic signed [GRAD_W-1:0] old_sum;

	assign accept   = start && (state_q == ST_IDLE);
	assign busy     = (state_q != ST_IDLE);
	assign rows_eff = ({6'd0, rows_cfg_q} > 17'(MAX_ROWS)) ? 17'(MAX_ROWS) : {6'd0, rows_cfg_q};
	assign vl       = (vlen_cfg_q == '0) ? VLEN_W'(1) :
		((vlen_cfg_q > VLEN_W'(MAX_VECTOR)) ? VLEN_W'(MAX_VECTOR) : vlen_cfg_q);
	assign tok_good = !token[WORD_W-1] && ({1'b0, token} < rows_eff);
	assign wr_good  = !token[WORD_W-1] && ({1'b0, token} < 17'(MAX_ROWS)) &&
		({1'b0, element_index} < VLEN_W'(MAX_VECTOR));
	assign pos_cached = {24'd0, position} < 32'(MAX_POSITIONS);
	assign pos_next   = {1'b0, position} + COUNT_W'(1);
	assign count_base = first ? '0 : count_q;
	assign tok_base   = AW'(AW'(token[RW-1:0]) * AW'(MAX_VECTOR));
	assign wr_addr    = tok_base + AW'(element_index);
	assign fwd_addr   = base_q + AW'(d_q);
	assign div_start  = (state_q == ST_GCHK) && (count_q != '0) && ({1'b0, elem_q} < vl);

	assign old_sum  = (grd_q[EPOCH_W+GRAD_W-1:GRAD_W] == epoch_q) ? grd_q[GRAD_W-1:0] : '0;
	assign sum_wide = {old_sum[GRAD_W-1], old_sum} + (GRAD_W+1)'(val_q);
	assign sum_sat  = (sum_wide > (GRAD_W+1)'(GRAD_MAX)) ? GRAD_MAX :
		((sum_wide < (GRAD_W+1)'(GRAD_MIN)) ? GRAD_MIN : sum_wide[GRAD_W-1:0]);

	assign result_strobe = strobe_q;
	assign kind          = kind_q;
	assign embed_value   = from_mem_q ? wrd_q : oembed_q;
	assign grad_sum      = ograd_q;
	assign out_element   = oelem_q;
	assign last          = olast_q;

	emb_remu u_remu (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (pos_q),
		.divisor  (count_q),
		.done     (div_done),
		.rem      (div_rem)
	);

	// Memories: weight table, gradient table with pass tags, token cache.
	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_WRITE) && wr_good) begin
			wmem[wr_addr] <= value;
		end
		if (state_q == ST_FWD) begin
			wrd_q <= wmem[fwd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_SWEEP) begin
			gmem[sweep_q] <= '0;
		end else if (state_q == ST_GSUM) begin
			gmem[gaddr_q] <= {epoch_q, sum_sat};
		end
		if (state_q == ST_GADR) begin
			grd_q <= gmem[gaddr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (accept && (req_type == REQ_FORWARD) && tok_good && pos_cached) begin
			cmem[position[CW-1:0]] <= token[RW-1:0];
		end
		if (div_done) begin
			crd_q <= cmem[div_rem[CW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			rows_cfg_q   <= 11'd1024;
			vlen_cfg_q   <= 7'd32;
			count_q      <= '0;
			epoch_q      <= EPOCH_W'(1);
			sweep_q      <= '0;
			sweep_grad_q <= 1'b0;
			base_q       <= '0;
			gaddr_q      <= '0;
			d_q          <= '0;
			pos_q        <= '0;
			elem_q       <= '0;
			val_q        <= '0;
			strobe_q     <= 1'b0;
			kind_q       <= KIND_ACK;
			oembed_q     <= '0;
			ograd_q      <= '0;
			oelem_q      <= '0;
			olast_q      <= 1'b0;
			from_mem_q   <= 1'b0;
		end else begin
			strobe_q   <= 1'b0;
			from_mem_q <= 1'b0;
			if (cfg_we) begin
				if (cfg_index == 1'b0) begin
					rows_cfg_q <= cfg_data;
				end else begin
					vlen_cfg_q <= cfg_data[VLEN_W-1:0];
				end
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						pos_q  <= position;
						elem_q <= element_index;
						val_q  <= value;
						unique case (req_type)
							REQ_WRITE: begin
								strobe_q <= 1'b1;
								kind_q   <= KIND_ACK;
								oembed_q <= value;
								ograd_q  <= '0;
								oelem_q  <= element_index;
								olast_q  <= 1'b1;
							end
							REQ_FORWARD: begin
								if (!tok_good) begin
									strobe_q <= 1'b1;
									kind_q   <= KIND_RANGE;
									oembed_q <= '0;
									ograd_q  <= '0;
									oelem_q  <= '0;
									olast_q  <= 1'b1;
								end else begin
									if (pos_cached && (pos_next > count_base)) begin
										count_q <= pos_next;
									end else begin
										count_q <= count_base;
									end
									base_q  <= tok_base;
									d_q     <= '0;
									state_q <= ST_FWD;
								end
							end
							REQ_GRAD: begin
								// A new backward pass retires every entry by moving to a fresh tag, or by a sweep when the tag wraps.
								if (first && (epoch_q == '1)) begin
									sweep_q      <= '0;
									sweep_grad_q <= 1'b1;
									state_q      <= ST_SWEEP;
								end else begin
									if (first) begin
										epoch_q <= epoch_q + EPOCH_W'(1);
									end
									state_q <= ST_GCHK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_SWEEP: begin
					sweep_q <= sweep_q + AW'(1);
					if (sweep_q == AW'(WORDS - 1)) begin
						epoch_q      <= EPOCH_W'(1);
						sweep_grad_q <= 1'b0;
						state_q      <= sweep_grad_q ? ST_GCHK : ST_IDLE;
					end
				end
				ST_FWD: begin
					strobe_q   <= 1'b1;
					from_mem_q <= 1'b1;
					kind_q     <= KIND_EMBED;
					ograd_q    <= '0;
					oelem_q    <= d_q[ELEM_W-1:0];
					olast_q    <= (d_q + VLEN_W'(1) == vl);
					d_q        <= d_q + VLEN_W'(1);
					if (d_q + VLEN_W'(1) == vl) begin
						state_q <= ST_IDLE;
					end
				end
				ST_GCHK: begin
					if (count_q == '0) begin
						strobe_q <= 1'b1;
						kind_q   <= KIND_NOCACHE;
						oembed_q <= '0;
						ograd_q  <= '0;
						oelem_q  <= '0;
						olast_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else if ({1'b0, elem_q} >= vl) begin
						strobe_q <= 1'b1;
						kind_q   <= KIND_GRAD;
						oembed_q <= '0;
						ograd_q  <= '0;
						oelem_q  <= elem_q;
						olast_q  <= 1'b1;
						state_q  <= ST_IDLE;
					end else begin
						state_q <= ST_GDIV;
					end
				end
				ST_GDIV: begin
					if (div_done) begin
						state_q <= ST_GROW;
					end
				end
				ST_GROW: begin
					gaddr_q <= AW'(AW'(crd_q) * AW'(MAX_VECTOR)) + AW'(elem_q);
					state_q <= ST_GADR;
				end
				ST_GADR: begin
					state_q <= ST_GSUM;
				end
				ST_GSUM: begin
					strobe_q <= 1'b1;
					kind_q   <= KIND_GRAD;
					oembed_q <= '0;
					ograd_q  <= sum_sat;
					oelem_q  <= elem_q;
					olast_q  <= 1'b1;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	a_div_in_gdiv: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_GDIV) else $error("remainder finished outside gradient wait");
	a_embed_stream: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q == KIND_EMBED) && !olast_q |=> strobe_q && (kind_q == KIND_EMBED))
		else $error("embedding stream broken before last element");
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && (kind_q != KIND_EMBED) |-> olast_q) else $error("single result without last");

endmodule

### verif/embedding_lookup_and_gradient_tb.sv
// Self-checking testbench for the embedding lookup and gradient engine.
module embedding_lookup_and_gradient_tb;
	import emb_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ROWS = 1024;
	localparam int VEC  = 64;
	localparam int NPOS = 256;

	typedef struct {
		req_t                     req;
		logic signed [WORD_W-1:0] tok;
		logic [POS_W-1:0]         pos;
		logic [ELEM_W-1:0]        el;
		logic signed [WORD_W-1:0] val;
		logic                     fst;
	} req_item_t;

	typedef struct {
		kind_t                    kind;
		logic signed [WORD_W-1:0] emb;
		logic signed [GRAD_W-1:0] gsum;
		logic [ELEM_W-1:0]        el;
		logic                     lst;
	} emb_result_t;

	class embed_scoreboard;
		emb_result_t              pending[$];
		logic [WORD_W-1:0]        weights[ROWS*VEC];
		logic [VEC-1:0]           row_mask[ROWS];
		int                       grads[ROWS*VEC];
		bit                       grad_ok[ROWS*VEC];
		int                       token_cache[NPOS];
		int                       cache_fill;
		int                       cached;
		int                       rows_cfg;
		int                       vlen_cfg;
		int                       results_seen;

		function new();
			foreach (row_mask[i]) row_mask[i] = '0;
			foreach (grad_ok[i]) grad_ok[i] = 0;
			cache_fill = 0;
			cached = 0;
			rows_cfg = 1024;
			vlen_cfg = 32;
			results_seen = 0;
		endfunction

		function int rows_eff();
			return (rows_cfg > ROWS) ? ROWS : rows_cfg;
		endfunction

		function int vlen_eff();
			if (vlen_cfg < 1) return 1;
			if (vlen_cfg > VEC) return VEC;
			return vlen_cfg;
		endfunction

		function void push(kind_t k, int emb, int gs, int el, bit lst);
			emb_result_t r;
			r.kind = k;
			r.emb = emb[WORD_W-1:0];
			r.gsum = gs[GRAD_W-1:0];
			r.el = el[ELEM_W-1:0];
			r.lst = lst;
			pending.push_back(r);
		endfunction

		// Works out the results of one accepted transfer and updates the state.
		function void note(req_item_t it);
			int t;
			int v;
			int a;
			int s;
			int vl;
			t = it.tok;
			v = it.val;
			vl = vlen_eff();
			case (it.req)
				REQ_WRITE: begin
					if (t >= 0 && t < ROWS) begin
						weights[t*VEC + it.el] = it.val;
						row_mask[t][it.el] = 1'b1;
					end
					push(KIND_ACK, v, 0, it.el, 1);
				end
				REQ_FORWARD: begin
					if (t < 0 || t >= rows_eff()) begin
						push(KIND_RANGE, 0, 0, 0, 1);
					end else begin
						if (it.fst) cached = 0;
						token_cache[it.pos] = t;
						if (it.pos + 1 > cached) cached = it.pos + 1;
						if (it.pos == cache_fill) cache_fill++;
						for (int d = 0; d < vl; d++)
							push(KIND_EMBED, weights[t*VEC + d], 0, d, d == vl - 1);
					end
				end
				REQ_GRAD: begin
					if (it.fst) foreach (grad_ok[i]) grad_ok[i] = 0;
					if (cached == 0) begin
						push(KIND_NOCACHE, 0, 0, 0, 1);
					end else if (it.el >= vl) begin
						push(KIND_GRAD, 0, 0, it.el, 1);
					end else begin
						a = token_cache[it.pos % cached] * VEC + it.el;
						s = (grad_ok[a] ? grads[a] : 0) + v;
						if (s > 8388607) s = 8388607;
						if (s < -8388608) s = -8388608;
						grads[a] = s;
						grad_ok[a] = 1;
						push(KIND_GRAD, 0, s, it.el, 1);
					end
				end
				default: ;
			endcase
		endfunction

		function bit check(emb_result_t got, output string msg);
			emb_result_t e;
			results_seen++;
			if (pending.size() == 0) begin
				msg = $sformatf("unexpected result kind %0d", got.kind);
				return 0;
			end
			e = pending.pop_front();
			if (got.kind !== e.kind || got.emb !== e.emb || got.gsum !== e.gsum ||
			    got.el !== e.el || got.lst !== e.lst) begin
				msg = $sformatf("got kind %0d emb %0d grad %0d el %0d last %0d, want %0d %0d %0d %0d %0d",
					got.kind, got.emb, got.gsum, got.el, got.lst,
					e.kind, e.emb, e.gsum, e.el, e.lst);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     start = 1'b0;
	logic                     busy;
	logic [1:0]               req_type = '0;
	logic signed [WORD_W-1:0] token = '0;
	logic [POS_W-1:0]         position = '0;
	logic [ELEM_W-1:0]        element_index = '0;
	logic signed [WORD_W-1:0] value = '0;
	logic                     first = 1'b0;
	logic                     result_strobe;
	logic [2:0]               kind;
	logic signed [WORD_W-1:0] embed_value;
	logic signed [GRAD_W-1:0] grad_sum;
	logic [ELEM_W-1:0]        out_element;
	logic                     last;
	logic                     cfg_we = 1'b0;
	logic                     cfg_index = 1'b0;
	logic [ROWS_W-1:0]        cfg_data = '0;

	embedding_lookup_and_gradient i_dut (.*);

	embed_scoreboard sb = new();
	int errors = 0;
	int transfers = 0;
	int loaded_rows[$] = '{0, 1, 1023};

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	task automatic report(string msg);
		errors++;
		$display("MISMATCH at %0t: %s", $realtime, msg);
	endtask

	always @(posedge clk) begin
		emb_result_t got;
		string msg;
		if (arst_n && result_strobe) begin
			got.kind = kind_t'(kind);
			got.emb = embed_value;
			got.gsum = grad_sum;
			got.el = out_element;
			got.lst = last;
			if (!sb.check(got, msg)) report(msg);
		end
	end

	task automatic send(req_t rq, int tk, int ps, int el, int vl, bit fs);
		req_item_t it;
		it.req = rq;
		it.tok = tk[WORD_W-1:0];
		it.pos = ps[POS_W-1:0];
		it.el = el[ELEM_W-1:0];
		it.val = vl[WORD_W-1:0];
		it.fst = fs;
		start <= 1'b1;
		req_type <= rq;
		token <= it.tok;
		position <= it.pos;
		element_index <= it.el;
		value <= it.val;
		first <= fs;
		@(posedge clk);
		while (busy) @(posedge clk);
		sb.note(it);
		transfers++;
	endtask

	task automatic pause(int n);
		start <= 1'b0;
		repeat (n) @(posedge clk);
	endtask

	// Waits for every expected result, then lets the longest stream finish.
	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (80) @(posedge clk);
		while (busy) @(posedge clk);
	endtask

	task automatic set_config(int rows, int vlen);
		drain();
		cfg_we <= 1'b1;
		cfg_index <= 1'b0;
		cfg_data <= rows[ROWS_W-1:0];
		@(posedge clk);
		cfg_index <= 1'b1;
		cfg_data <= vlen[ROWS_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.rows_cfg = rows;
		sb.vlen_cfg = vlen & 8'h7F;
	endtask

	function automatic int good_token();
		int ok[$];
		foreach (loaded_rows[i])
			if (loaded_rows[i] < sb.rows_eff() && &sb.row_mask[loaded_rows[i]])
				ok.push_back(loaded_rows[i]);
		if (ok.size() == 0) return -1;
		return ok[$urandom_range(ok.size() - 1)];
	endfunction

	task automatic random_item(output bit counted);
		int sel;
		int tk;
		int lim;
		sel = $urandom_range(99);
		counted = 1;
		if (sel < 15) begin
			if ($urandom_range(9) < 7)
				tk = loaded_rows[$urandom_range(loaded_rows.size() - 1)];
			else
				tk = $signed(16'($urandom));
			send(REQ_WRITE, tk, $urandom, $urandom, $urandom, $urandom);
		end else if (sel < 45) begin
			tk = good_token();
			lim = (sb.cache_fill > NPOS - 1) ? NPOS - 1 : sb.cache_fill;
			if (tk >= 0 && $urandom_range(9) < 8)
				send(REQ_FORWARD, tk, $urandom_range(lim), $urandom, $urandom,
					$urandom_range(4) == 0);
			else if ($urandom_range(1))
				send(REQ_FORWARD, -1 - $urandom_range(32767), $urandom, $urandom, $urandom,
					$urandom);
			else
				send(REQ_FORWARD, $urandom_range(32767, sb.rows_eff()), $urandom, $urandom,
					$urandom, $urandom);
		end else if (sel < 90) begin
			send(REQ_GRAD, $urandom, $urandom, $urandom, $urandom, $urandom_range(9) == 0);
		end else begin
			send(REQ_NONE, $urandom, $urandom, $urandom, $urandom, $urandom);
			counted = 0;
		end
	endtask

	task automatic random_phase(int count, int idle_pct);
		int n;
		bit counted;
		n = 0;
		while (n < count) begin
			random_item(counted);
			if (counted) n++;
			if ($urandom_range(99) < idle_pct) pause($urandom_range(1, 5));
		end
	endtask

	initial begin
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		drain();
		// With nothing cached yet, gradients hit the empty cache case.
		send(REQ_GRAD, 0, 0, 0, 100, 1);
		send(REQ_GRAD, 0, 255, 63, -32768, 0);
		send(REQ_NONE, -1, 255, 63, -1, 1);
		// Row writes outside the table are still acknowledged.
		send(REQ_WRITE, -32768, 0, 63, 32767, 0);
		send(REQ_WRITE, 1024, 0, 0, -32768, 1);
		send(REQ_WRITE, 32767, 255, 0, 0, 0);
		foreach (loaded_rows[i])
			for (int e = 0; e < VEC; e++)
				send(REQ_WRITE, loaded_rows[i], 0, e, $urandom, 0);
		send(REQ_FORWARD, 1024, 0, 0, 0, 1);
		send(REQ_FORWARD, -32768, 0, 0, 0, 1);
		send(REQ_FORWARD, 1023, 0, 0, 0, 1);
		send(REQ_FORWARD, 0, 1, 0, 0, 0);
		send(REQ_FORWARD, 1, 2, 0, 0, 0);
		send(REQ_GRAD, 0, 0, 0, 32767, 1);
		send(REQ_GRAD, 0, 3, 0, -32768, 0);
		send(REQ_GRAD, 0, 255, 31, 1, 0);
		send(REQ_GRAD, 0, 7, 32, 5, 0);
		send(REQ_GRAD, 0, 4, 63, -7, 0);
		drain();

		set_config(1, 1);
		random_phase(40, 21);
		set_config(1024, 64);
		random_phase(40, 83);
		set_config(2047, 127);
		random_phase(40, 0);
		set_config(0, 0);
		random_phase(10, 0);
		drain();

		$display("Covered %0d transfers and %0d results: writes, lookups, range errors,",
			transfers, sb.results_seen);
		$display("empty cache, gradient sums and register extremes.");
		if (errors == 0)
			$display("embedding_lookup_and_gradient test passed");
		else
			$display("embedding_lookup_and_gradient test failed");
		$finish;
	end

	initial begin
		#50ms;
		$display("embedding_lookup_and_gradient test failed");
		$finish;
	end

endmodule
